// ----- design/wvh_pkg.sv -----
package wvh_pkg;

    // sizes of the stores
    localparam int MAX_VERTICES = 4096;
    localparam int VTX_BITS     = 12;
    localparam int COUNT_BITS   = 13;
    localparam int HASH_BUCKETS = 1024;
    localparam int HASH_BITS    = 10;
    localparam int BUCKET_SLOTS = 8;
    localparam int SLOT_BITS    = 3;
    localparam int FILL_BITS    = 4;
    localparam int CELL_BITS    = 16;

    // slot layout: {vertex id, key z, key y, key x}
    localparam int KEY_W  = 3 * CELL_BITS;
    localparam int SLOT_W = KEY_W + VTX_BITS;
    localparam int ROW_W  = BUCKET_SLOTS * SLOT_W + FILL_BITS;

    // vertex store word: {remap, z, y, x}
    localparam int VWORD_W = 96 + VTX_BITS;

    localparam logic [31:0] PRIME_X = 32'd73856093;
    localparam logic [31:0] PRIME_Y = 32'd19349663;
    localparam logic [31:0] PRIME_Z = 32'd83492791;

    localparam logic [47:0] INV_RESET = 48'd6553600000;

    // configuration register indexes
    localparam logic CFG_INV_CELL = 1'b0;
    localparam logic CFG_RADIUS   = 1'b1;

    // commands
    localparam logic [1:0] CMD_VERTEX   = 2'd0;
    localparam logic [1:0] CMD_TRIANGLE = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_CLEAR    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_STORE_FULL  = 2'd1;
    localparam logic [1:0] ST_BUCKET_FULL = 2'd2;
    localparam logic [1:0] ST_BAD_CORNER  = 2'd3;

    typedef logic [2:0][CELL_BITS-1:0] cell_key_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_VERTEX,
        EM_FULL,
        EM_TRIANGLE,
        EM_BAD,
        EM_CLEAR
    } emit_t;

    typedef enum logic [1:0] {
        VS_SLOT,
        VS_A,
        VS_B,
        VS_C
    } vsel_t;

    // controller to datapath
    typedef struct packed {
        logic                 take;
        logic                 cell_load;
        logic                 cell_mul;
        logic                 cell_fin1;
        logic                 cell_fin2;
        logic [1:0]           axis;
        logic                 nb_latch;
        logic [1:0]           off_x;
        logic [1:0]           off_y;
        logic [1:0]           off_z;
        logic                 row_read;
        logic [SLOT_BITS-1:0] slot;
        logic                 vtx_read;
        vsel_t                vtx_sel;
        logic                 tri_cap;
        logic                 diff;
        logic                 mul;
        logic                 acc_clear;
        logic                 acc_add;
        logic                 take_match;
        logic                 new_index;
        logic                 row_insert;
        logic                 vtx_write;
        logic                 clr_row;
        logic [HASH_BITS-1:0] clr_addr;
        logic                 counts_clear;
        emit_t                emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic store_full;
        logic corner_bad;
        logic slot_valid;
        logic slot_match;
        logic dist_ok;
    } dp_stat_t;

    // bucket of a cell: only the low bits of each product reach the result
    function automatic logic [HASH_BITS-1:0] bucket_of(input cell_key_t k);
        logic [2*HASH_BITS-1:0] px;
        logic [2*HASH_BITS-1:0] py;
        logic [2*HASH_BITS-1:0] pz;
        px = k[0][HASH_BITS-1:0] * PRIME_X[HASH_BITS-1:0];
        py = k[1][HASH_BITS-1:0] * PRIME_Y[HASH_BITS-1:0];
        pz = k[2][HASH_BITS-1:0] * PRIME_Z[HASH_BITS-1:0];
        return px[HASH_BITS-1:0] ^ py[HASH_BITS-1:0] ^ pz[HASH_BITS-1:0];
    endfunction

endpackage

// ----- design/vertex_weld_spatial_hash.sv -----
// Vertex welder. Raise start while busy is low to hand over one word: a vertex,
// a triangle or a table clear. Every result appears for exactly one cycle with
// done high and cannot be held off, so the receiver must take it then; done
// rises in the cycle that busy falls. A vertex with every neighbour bucket
// empty runs a store check, the split multiply of the cell unit on each axis
// (load, multiply, fin1, fin2), then a key latch, bucket-row read and first
// slot check for each of the 27 neighbour cells, and then issues the index,
// inserts into the bucket and writes the vertex store. Each further occupied
// slot looked at adds a slot check, and each slot whose cell key matches adds
// a vertex read, three axis passes through one multiplier and a distance
// compare; the search stops at the first weld. A triangle makes three reads of
// the vertex store through its one read port; a vertex on a full store and a
// triangle with a corner out of range end at the first check. A degenerate
// triangle and an unused command give no result. A table clear, and the pass
// that follows reset, sweeps the 1024 bucket rows one a cycle, and busy stays
// high through the sweep. Configuration writes are taken at any time but
// belong to idle periods.
module vertex_weld_spatial_hash (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   cmd,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic [wvh_pkg::VTX_BITS-1:0] corner_a,
    input  logic [wvh_pkg::VTX_BITS-1:0] corner_b,
    input  logic [wvh_pkg::VTX_BITS-1:0] corner_c,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [63:0]                  cfg_data,
    output logic                         done,
    output logic [1:0]                   kind,
    output logic [wvh_pkg::VTX_BITS-1:0] welded_a,
    output logic [wvh_pkg::VTX_BITS-1:0] welded_b,
    output logic [wvh_pkg::VTX_BITS-1:0] welded_c,
    output logic                         is_new,
    output logic [1:0]                   status
);
    import wvh_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t stat;

    wvh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .dcmd  (dcmd),
        .busy  (busy)
    );

    wvh_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dcmd      (dcmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .corner_a  (corner_a),
        .corner_b  (corner_b),
        .corner_c  (corner_c),
        .done      (done),
        .kind      (kind),
        .welded_a  (welded_a),
        .welded_b  (welded_b),
        .welded_c  (welded_c),
        .is_new    (is_new),
        .status    (status)
    );

endmodule

// ----- design/wvh_ctrl.sv -----
module wvh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  wvh_pkg::dp_stat_t stat,
    output wvh_pkg::dp_cmd_t  dcmd,
    output logic              busy
);
    import wvh_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_VCHK, S_CLOAD, S_CMUL, S_CFIN1, S_CFIN2,
        S_NLATCH, S_NREAD, S_SCHECK, S_DREAD, S_DDIFF, S_DMUL, S_DACC, S_DCMP,
        S_VNEW, S_ILATCH, S_IREAD, S_IWRITE, S_VDONE,
        S_TCHK, S_TRA, S_TRB, S_TRC, S_TRL, S_TEMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           axis_reg, axis_next;
    logic [1:0]           dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic [HASH_BITS-1:0] clr_reg, clr_next;
    logic                 found_reg, found_next;
    logic                 emit_clr_reg, emit_clr_next;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(BUCKET_SLOTS - 1);
    localparam logic [HASH_BITS-1:0] LAST_ROW  = HASH_BITS'(HASH_BUCKETS - 1);

    assign busy = (state_reg != S_IDLE);

    // next state, counters and command decode
    always_comb
    begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        dz_next       = dz_reg;
        slot_next     = slot_reg;
        clr_next      = clr_reg;
        found_next    = found_reg;
        emit_clr_next = emit_clr_reg;
        dcmd          = '0;
        dcmd.axis     = axis_reg;
        dcmd.slot     = slot_reg;
        dcmd.off_x    = dx_reg;
        dcmd.off_y    = dy_reg;
        dcmd.off_z    = dz_reg;
        dcmd.clr_addr = clr_reg;
        dcmd.vtx_sel  = VS_SLOT;
        dcmd.emit     = EM_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dcmd.take  = 1'b1;
                    found_next = 1'b0;
                    unique case (cmd)
                        CMD_VERTEX:   state_next = S_VCHK;
                        CMD_TRIANGLE: state_next = S_TCHK;
                        CMD_CLEAR:
                        begin
                            state_next    = S_CLEAR;
                            clr_next      = '0;
                            emit_clr_next = 1'b1;
                        end
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                dcmd.clr_row      = 1'b1;
                dcmd.counts_clear = 1'b1;
                clr_next          = clr_reg + 1'b1;
                if (clr_reg == LAST_ROW)
                begin
                    if (emit_clr_reg)
                        dcmd.emit = EM_CLEAR;
                    state_next = S_IDLE;
                end
            end
            S_VCHK:
            begin
                axis_next = 2'd0;
                if (stat.store_full)
                begin
                    dcmd.emit  = EM_FULL;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_CLOAD;
            end
            S_CLOAD:
            begin
                dcmd.cell_load = 1'b1;
                state_next     = S_CMUL;
            end
            S_CMUL:
            begin
                dcmd.cell_mul = 1'b1;
                state_next    = S_CFIN1;
            end
            S_CFIN1:
            begin
                dcmd.cell_fin1 = 1'b1;
                state_next     = S_CFIN2;
            end
            S_CFIN2:
            begin
                dcmd.cell_fin2 = 1'b1;
                if (axis_reg == 2'd2)
                begin
                    dx_next    = 2'd0;
                    dy_next    = 2'd0;
                    dz_next    = 2'd0;
                    state_next = S_NLATCH;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_CLOAD;
                end
            end
            S_NLATCH:
            begin
                dcmd.nb_latch = 1'b1;
                state_next    = S_NREAD;
            end
            S_NREAD:
            begin
                dcmd.row_read = 1'b1;
                slot_next     = '0;
                state_next    = S_SCHECK;
            end
            S_SCHECK:
            begin
                if (stat.slot_valid && stat.slot_match)
                begin
                    state_next = S_DREAD;
                end
                else if (stat.slot_valid && (slot_reg != LAST_SLOT))
                begin
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    // next neighbour cell, z innermost
                    state_next = S_NLATCH;
                    if (dz_reg != 2'd2)
                        dz_next = dz_reg + 2'd1;
                    else if (dy_reg != 2'd2)
                    begin
                        dz_next = 2'd0;
                        dy_next = dy_reg + 2'd1;
                    end
                    else if (dx_reg != 2'd2)
                    begin
                        dz_next = 2'd0;
                        dy_next = 2'd0;
                        dx_next = dx_reg + 2'd1;
                    end
                    else
                        state_next = S_VNEW;
                end
            end
            S_DREAD:
            begin
                dcmd.vtx_read  = 1'b1;
                dcmd.vtx_sel   = VS_SLOT;
                dcmd.acc_clear = 1'b1;
                axis_next      = 2'd0;
                state_next     = S_DDIFF;
            end
            S_DDIFF:
            begin
                dcmd.diff  = 1'b1;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                dcmd.mul   = 1'b1;
                state_next = S_DACC;
            end
            S_DACC:
            begin
                dcmd.acc_add = 1'b1;
                if (axis_reg == 2'd2)
                    state_next = S_DCMP;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DDIFF;
                end
            end
            S_DCMP:
            begin
                if (stat.dist_ok)
                begin
                    dcmd.take_match = 1'b1;
                    found_next      = 1'b1;
                    state_next      = S_VNEW;
                end
                else if (slot_reg != LAST_SLOT)
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_SCHECK;
                end
                else
                begin
                    // bucket exhausted: next neighbour cell, or a new vertex after the last
                    state_next = S_SCHECK;
                    if (dz_reg != 2'd2)
                    begin
                        dz_next    = dz_reg + 2'd1;
                        state_next = S_NLATCH;
                    end
                    else if (dy_reg != 2'd2)
                    begin
                        dz_next    = 2'd0;
                        dy_next    = dy_reg + 2'd1;
                        state_next = S_NLATCH;
                    end
                    else if (dx_reg != 2'd2)
                    begin
                        dz_next    = 2'd0;
                        dy_next    = 2'd0;
                        dx_next    = dx_reg + 2'd1;
                        state_next = S_NLATCH;
                    end
                    else
                        state_next = S_VNEW;
                end
            end
            S_VNEW:
            begin
                dcmd.new_index = !found_reg;
                state_next     = S_ILATCH;
            end
            S_ILATCH:
            begin
                // own cell: offset of one on every axis
                dcmd.nb_latch = 1'b1;
                dcmd.off_x    = 2'd1;
                dcmd.off_y    = 2'd1;
                dcmd.off_z    = 2'd1;
                state_next    = S_IREAD;
            end
            S_IREAD:
            begin
                dcmd.row_read = 1'b1;
                state_next    = S_IWRITE;
            end
            S_IWRITE:
            begin
                dcmd.row_insert = 1'b1;
                state_next      = S_VDONE;
            end
            S_VDONE:
            begin
                dcmd.vtx_write = 1'b1;
                dcmd.emit      = EM_VERTEX;
                state_next     = S_IDLE;
            end
            S_TCHK:
            begin
                if (stat.corner_bad)
                begin
                    dcmd.emit  = EM_BAD;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_TRA;
            end
            S_TRA:
            begin
                dcmd.vtx_read = 1'b1;
                dcmd.vtx_sel  = VS_A;
                state_next    = S_TRB;
            end
            S_TRB:
            begin
                dcmd.vtx_read = 1'b1;
                dcmd.vtx_sel  = VS_B;
                dcmd.tri_cap  = 1'b1;
                dcmd.axis     = 2'd0;
                state_next    = S_TRC;
            end
            S_TRC:
            begin
                dcmd.vtx_read = 1'b1;
                dcmd.vtx_sel  = VS_C;
                dcmd.tri_cap  = 1'b1;
                dcmd.axis     = 2'd1;
                state_next    = S_TRL;
            end
            S_TRL:
            begin
                dcmd.tri_cap = 1'b1;
                dcmd.axis    = 2'd2;
                state_next   = S_TEMIT;
            end
            S_TEMIT:
            begin
                dcmd.emit  = EM_TRIANGLE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and counters; reset starts a silent clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            axis_reg     <= '0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            dz_reg       <= '0;
            slot_reg     <= '0;
            clr_reg      <= '0;
            found_reg    <= 1'b0;
            emit_clr_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            dz_reg       <= dz_next;
            slot_reg     <= slot_next;
            clr_reg      <= clr_next;
            found_reg    <= found_next;
            emit_clr_reg <= emit_clr_next;
        end
    end

endmodule

// ----- design/wvh_datapath.sv -----
module wvh_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wvh_pkg::dp_cmd_t             dcmd,
    output wvh_pkg::dp_stat_t            stat,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [63:0]                  cfg_data,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic [wvh_pkg::VTX_BITS-1:0] corner_a,
    input  logic [wvh_pkg::VTX_BITS-1:0] corner_b,
    input  logic [wvh_pkg::VTX_BITS-1:0] corner_c,
    output logic                         done,
    output logic [1:0]                   kind,
    output logic [wvh_pkg::VTX_BITS-1:0] welded_a,
    output logic [wvh_pkg::VTX_BITS-1:0] welded_b,
    output logic [wvh_pkg::VTX_BITS-1:0] welded_c,
    output logic                         is_new,
    output logic [1:0]                   status
);
    import wvh_pkg::*;

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(MAX_VERTICES);
    localparam logic [48:0] POS_LIM = 49'((1 << (CELL_BITS - 1)) - 1);
    localparam logic [48:0] NEG_LIM = 49'(1 << (CELL_BITS - 1));

    // configuration
    logic [47:0] inv_reg;
    logic [63:0] rad_reg;

    // item and counts
    logic [2:0][31:0]          pos_reg;
    logic [2:0][VTX_BITS-1:0]  corner_reg;
    logic [COUNT_BITS-1:0]     vcount_reg, ucount_reg;

    // cell unit
    logic [31:0]               cm_reg;
    logic                      cneg_reg, cfrac_reg;
    logic [47:0]               pl_reg;
    logic [63:0]               ph_reg;
    logic [63:0]               t_reg;
    cell_key_t                 key_reg, nk_reg;

    // distance unit
    logic [31:0]               diff_reg;
    logic [63:0]               sq_reg, acc_reg;

    // results
    logic [VTX_BITS-1:0]       merged_reg;
    logic                      new_reg;
    logic [1:0]                ins_st_reg;
    logic [2:0][VTX_BITS-1:0]  tri_reg;

    logic                      done_reg;
    logic [1:0]                kind_reg, status_reg;
    logic [VTX_BITS-1:0]       wa_reg, wb_reg, wc_reg;
    logic                      isnew_reg;

    // memories
    logic [ROW_W-1:0]          row_mem [HASH_BUCKETS];
    logic [ROW_W-1:0]          row_q;
    logic [VWORD_W-1:0]        vtx_mem [MAX_VERTICES];
    logic [VWORD_W-1:0]        vtx_q;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= INV_RESET;
            rad_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INV_CELL: inv_reg <= cfg_data[47:0];
                CFG_RADIUS:   rad_reg <= cfg_data;
                default:      rad_reg <= rad_reg;
            endcase
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (dcmd.take)
        begin
            pos_reg    <= {pos_z, pos_y, pos_x};
            corner_reg <= {corner_c, corner_b, corner_a};
        end
    end

    // status towards the controller
    logic [SLOT_W-1:0]   cur_slot;
    logic [FILL_BITS-1:0] row_fill;
    logic [HASH_BITS-1:0] nk_bucket;

    assign cur_slot  = row_q[dcmd.slot*SLOT_W +: SLOT_W];
    assign row_fill  = row_q[ROW_W-1 -: FILL_BITS];
    assign nk_bucket = bucket_of(nk_reg);

    assign stat.store_full = (vcount_reg == FULL_COUNT);
    assign stat.corner_bad = ({1'b0, corner_reg[0]} >= vcount_reg)
                          || ({1'b0, corner_reg[1]} >= vcount_reg)
                          || ({1'b0, corner_reg[2]} >= vcount_reg);
    assign stat.slot_valid = ({1'b0, dcmd.slot} < row_fill);
    assign stat.slot_match = (cur_slot[KEY_W-1:0] == nk_reg);
    assign stat.dist_ok    = (acc_reg <= rad_reg);

    // cell unit: magnitude, split product, scale and saturate
    logic [31:0] raw;
    logic [63:0] t_sum;
    logic [47:0] q;
    logic [48:0] q_up;
    logic [48:0] q_sat;

    assign raw   = pos_reg[dcmd.axis];
    assign t_sum = ph_reg + {32'd0, pl_reg[47:16]};
    assign q     = t_reg[63:16];
    assign q_up  = {1'b0, q} + {48'd0, cfrac_reg};

    always_comb
    begin
        if (!cneg_reg)
            q_sat = ({1'b0, q} > POS_LIM) ? POS_LIM : {1'b0, q};
        else
            q_sat = (q_up > NEG_LIM) ? NEG_LIM : q_up;
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.cell_load)
        begin
            cneg_reg <= raw[31];
            cm_reg   <= raw[31] ? (32'd0 - raw) : raw;
        end
        if (dcmd.cell_mul)
        begin
            pl_reg <= cm_reg * inv_reg[15:0];
            ph_reg <= cm_reg * inv_reg[47:16];
        end
        if (dcmd.cell_fin1)
        begin
            t_reg     <= t_sum;
            cfrac_reg <= (t_sum[15:0] != 16'd0) || (pl_reg[15:0] != 16'd0);
        end
        if (dcmd.cell_fin2)
        begin
            key_reg[dcmd.axis] <= cneg_reg ? (CELL_BITS'(0) - q_sat[CELL_BITS-1:0])
                                           : q_sat[CELL_BITS-1:0];
        end
        // neighbour key wraps within the cell width
        if (dcmd.nb_latch)
        begin
            nk_reg[0] <= key_reg[0] + CELL_BITS'(dcmd.off_x) - CELL_BITS'(1);
            nk_reg[1] <= key_reg[1] + CELL_BITS'(dcmd.off_y) - CELL_BITS'(1);
            nk_reg[2] <= key_reg[2] + CELL_BITS'(dcmd.off_z) - CELL_BITS'(1);
        end
    end

    // distance unit: one axis per pass, saturating sum
    logic [31:0] st_axis;
    logic [32:0] d_ext;
    logic [64:0] acc_sum;

    assign st_axis = vtx_q[dcmd.axis*32 +: 32];
    assign d_ext   = {st_axis[31], st_axis} - {pos_reg[dcmd.axis][31], pos_reg[dcmd.axis]};
    assign acc_sum = {1'b0, acc_reg} + {1'b0, sq_reg};

    always_ff @(posedge clk)
    begin
        if (dcmd.diff)
            diff_reg <= d_ext[32] ? 32'(33'd0 - d_ext) : d_ext[31:0];
        if (dcmd.mul)
            sq_reg <= diff_reg * diff_reg;
        if (dcmd.acc_clear)
            acc_reg <= '0;
        else if (dcmd.acc_add)
            acc_reg <= acc_sum[64] ? '1 : acc_sum[63:0];
    end

    // bucket rows: clearing pass and insertion share the write port
    logic [ROW_W-1:0] row_new;
    logic             row_room;

    assign row_room = (row_fill < FILL_BITS'(BUCKET_SLOTS));

    always_comb
    begin
        row_new = row_q;
        row_new[row_fill[SLOT_BITS-1:0]*SLOT_W +: SLOT_W] =
            {vcount_reg[VTX_BITS-1:0], key_reg};
        row_new[ROW_W-1 -: FILL_BITS] = row_fill + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.clr_row)
            row_mem[dcmd.clr_addr] <= '0;
        else if (dcmd.row_insert && row_room)
            row_mem[nk_bucket] <= row_new;
        if (dcmd.row_read)
            row_q <= row_mem[nk_bucket];
    end

    // vertex store
    logic [VTX_BITS-1:0] vtx_addr;

    always_comb
    begin
        unique case (dcmd.vtx_sel)
            VS_SLOT: vtx_addr = cur_slot[SLOT_W-1 -: VTX_BITS];
            VS_A:    vtx_addr = corner_reg[0];
            VS_B:    vtx_addr = corner_reg[1];
            VS_C:    vtx_addr = corner_reg[2];
            default: vtx_addr = corner_reg[0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.vtx_write)
            vtx_mem[vcount_reg[VTX_BITS-1:0]] <= {merged_reg, pos_reg};
        if (dcmd.vtx_read)
            vtx_q <= vtx_mem[vtx_addr];
    end

    // merged index and insertion status
    always_ff @(posedge clk)
    begin
        if (dcmd.take)
            new_reg <= 1'b0;
        if (dcmd.take_match)
            merged_reg <= vtx_q[VWORD_W-1 -: VTX_BITS];
        else if (dcmd.new_index)
        begin
            merged_reg <= ucount_reg[VTX_BITS-1:0];
            new_reg    <= 1'b1;
        end
        if (dcmd.row_insert)
            ins_st_reg <= row_room ? ST_OK : ST_BUCKET_FULL;
        if (dcmd.tri_cap)
            tri_reg[dcmd.axis] <= vtx_q[VWORD_W-1 -: VTX_BITS];
    end

    // counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            ucount_reg <= '0;
        end
        else if (dcmd.counts_clear)
        begin
            vcount_reg <= '0;
            ucount_reg <= '0;
        end
        else
        begin
            if (dcmd.vtx_write)
                vcount_reg <= vcount_reg + 1'b1;
            if (dcmd.new_index)
                ucount_reg <= ucount_reg + 1'b1;
        end
    end

    // result word
    logic degenerate;

    assign degenerate = (tri_reg[0] == tri_reg[1]) || (tri_reg[1] == tri_reg[2])
                     || (tri_reg[0] == tri_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (dcmd.emit != EM_NONE)
                     && !((dcmd.emit == EM_TRIANGLE) && degenerate);
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= KIND_VERTEX;
        wa_reg     <= '0;
        wb_reg     <= '0;
        wc_reg     <= '0;
        isnew_reg  <= 1'b0;
        status_reg <= ST_OK;
        unique case (dcmd.emit)
            EM_VERTEX:
            begin
                wa_reg     <= merged_reg;
                isnew_reg  <= new_reg;
                status_reg <= ins_st_reg;
            end
            EM_FULL:
                status_reg <= ST_STORE_FULL;
            EM_TRIANGLE:
            begin
                kind_reg <= KIND_TRIANGLE;
                wa_reg   <= tri_reg[0];
                wb_reg   <= tri_reg[1];
                wc_reg   <= tri_reg[2];
            end
            EM_BAD:
            begin
                kind_reg   <= KIND_TRIANGLE;
                status_reg <= ST_BAD_CORNER;
            end
            EM_CLEAR:
                kind_reg <= KIND_CLEAR;
            default:
                kind_reg <= KIND_VERTEX;
        endcase
    end

    assign done     = done_reg;
    assign kind     = kind_reg;
    assign welded_a = wa_reg;
    assign welded_b = wb_reg;
    assign welded_c = wc_reg;
    assign is_new   = isnew_reg;
    assign status   = status_reg;

endmodule
